[rtl/core/pgt_pkg.sv]
// ----------------------------------------------------------------------------
// pgt_pkg
// Types and codes shared by the process group table: command and status
// codes, the request and response transfer structs and the slot entry layout.
// ----------------------------------------------------------------------------
package pgt_pkg;

  // command codes
  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_PUT     = 3'd2;
  localparam logic [2:0] CMD_ADD     = 3'd3;
  localparam logic [2:0] CMD_REMOVE  = 3'd4;
  localparam logic [2:0] CMD_RAISE   = 3'd5;
  localparam logic [2:0] CMD_TAKE    = 3'd6;
  localparam logic [2:0] CMD_QUERY   = 3'd7;

  // status codes
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_IGNORED = 2'd2;

  // saturation limit of the 8-bit counters
  localparam logic [7:0] CNT_MAX     = 8'hFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  slot;
    logic [15:0] new_group_id;
    logic [15:0] new_leader_id;
    logic [15:0] new_parent_id;
    logic [15:0] new_pgroup_id;
    logic [15:0] new_session_id;
    logic [7:0]  new_terminal_id;
    logic [4:0]  new_exit_signal;
    logic [5:0]  signal_number;
    logic [31:0] blocked_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  result_slot;
    logic [15:0] group_id_out;
    logic [15:0] leader_id_out;
    logic [15:0] parent_id_out;
    logic [15:0] pgroup_id_out;
    logic [15:0] session_id_out;
    logic [7:0]  terminal_id_out;
    logic [4:0]  exit_signal_out;
    logic [7:0]  live_count_out;
    logic [4:0]  signal_taken;
  } out_item_t;

  // one slot as held in the table memory
  typedef struct packed {
    logic [7:0]  ref_count;
    logic [7:0]  live_count;
    logic [15:0] group_id;
    logic [15:0] leader_id;
    logic [15:0] parent_id;
    logic [15:0] pgroup_id;
    logic [15:0] session_id;
    logic [7:0]  terminal_id;
    logic [4:0]  exit_sig;
    logic [31:0] pending;
  } entry_t;

endpackage

[rtl/core/process_group_table.sv]
// ----------------------------------------------------------------------------
// process_group_table
// Reference counted table of process group slots with a per-slot pending
// signal mask. Slot contents live in one synchronous memory; used bits and
// the lowest-free-slot search live in flops.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid / in_data, results leave on out_valid /
//   out_data; a transfer happens on a clock edge with valid high and stall
//   low. Every request yields exactly one result, in order.
//   A request first reads its slot entry from the table memory into a
//   register, then modifies it, writes it back and loads the output
//   register. No new request is taken until the current one has been
//   written back and its result loaded into the output register.
//   in_stall is high while a request is in flight. When the receiver stalls
//   out, the finished result holds in the output register and the request
//   in flight waits in its write-back step until the output register frees
//   up; no following request is taken meanwhile.
//   Reset clears all used bits, so every slot reads as empty; the memory
//   itself needs no clearing pass because create rewrites a whole entry.
// ----------------------------------------------------------------------------
module process_group_table
  import pgt_pkg::*;
#(
  parameter int MAX_SLOTS   = 64,
  parameter int NUM_SIGNALS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  // signals that may be raised or taken: 1 .. NUM_SIGNALS-1
  localparam logic [31:0] SIG_MASK =
    ((NUM_SIGNALS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << NUM_SIGNALS) - 32'd1)) & ~32'd1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                 state_r;
  in_item_t             req_r;
  logic [SLOT_W-1:0]    addr_r;
  logic                 in_range_r;
  logic [MAX_SLOTS-1:0] used_r;
  entry_t               mem [MAX_SLOTS];
  entry_t               rd_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 accept;
  logic                 go;
  logic [SLOT_W-1:0]    free_idx;
  logic                 full;
  logic                 slot_ok;
  logic [SLOT_W-1:0]    wr_addr;
  entry_t               entry_nxt;
  logic                 wr_en;
  logic                 set_used;
  logic                 clr_used;
  out_item_t            out_nxt;
  logic [31:0]          deliverable;
  logic [4:0]           taken;
  logic                 sig_ok;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign go        = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SLOT_W'(i);
        full     = 1'b0;
      end
    end
  end

  // lowest pending unblocked signal
  always_comb begin
    deliverable = rd_r.pending & ~req_r.blocked_mask & SIG_MASK;
    taken       = '0;
    for (int i = 31; i >= 1; i--) begin
      if (deliverable[i]) begin
        taken = 5'(i);
      end
    end
  end

  assign slot_ok = in_range_r && used_r[addr_r];
  assign sig_ok  = (req_r.signal_number != 6'd0) &&
                   (32'(req_r.signal_number) < 32'(NUM_SIGNALS)) &&
                   (req_r.signal_number < 6'd32);

  // modify step
  always_comb begin
    entry_nxt = rd_r;
    wr_en     = 1'b0;
    wr_addr   = addr_r;
    set_used  = 1'b0;
    clr_used  = 1'b0;
    out_nxt   = '0;
    if (req_r.command == CMD_CREATE) begin
      if (full) begin
        out_nxt.status = STS_FULL;
      end else begin
        entry_nxt.ref_count   = 8'd1;
        entry_nxt.live_count  = 8'd0;
        entry_nxt.group_id    = req_r.new_group_id;
        entry_nxt.leader_id   = req_r.new_leader_id;
        entry_nxt.parent_id   = req_r.new_parent_id;
        entry_nxt.pgroup_id   = req_r.new_pgroup_id;
        entry_nxt.session_id  = req_r.new_session_id;
        entry_nxt.terminal_id = req_r.new_terminal_id;
        entry_nxt.exit_sig    = req_r.new_exit_signal;
        entry_nxt.pending     = '0;
        wr_en                 = 1'b1;
        wr_addr               = free_idx;
        set_used              = 1'b1;
        out_nxt.status        = STS_DONE;
        out_nxt.result_slot   = 6'(free_idx);
      end
    end else if (!slot_ok) begin
      out_nxt.status = STS_IGNORED;
    end else begin
      out_nxt.status = STS_DONE;
      wr_en          = 1'b1;
      case (req_r.command)
        CMD_GET: begin
          if (rd_r.ref_count != CNT_MAX) begin
            entry_nxt.ref_count = rd_r.ref_count + 8'd1;
          end
        end
        CMD_PUT: begin
          if (rd_r.ref_count == 8'd0) begin
            out_nxt.status = STS_IGNORED;
          end else begin
            entry_nxt.ref_count = rd_r.ref_count - 8'd1;
            if (rd_r.ref_count == 8'd1) begin
              clr_used = 1'b1;
            end
          end
        end
        CMD_ADD: begin
          if (rd_r.live_count != CNT_MAX) begin
            entry_nxt.live_count = rd_r.live_count + 8'd1;
          end
        end
        CMD_REMOVE: begin
          if (rd_r.live_count == 8'd0) begin
            out_nxt.status = STS_IGNORED;
          end else begin
            entry_nxt.live_count = rd_r.live_count - 8'd1;
          end
        end
        CMD_RAISE: begin
          if (!sig_ok) begin
            out_nxt.status = STS_IGNORED;
          end else begin
            entry_nxt.pending = rd_r.pending | (32'd1 << req_r.signal_number[4:0]);
          end
        end
        CMD_TAKE: begin
          entry_nxt.pending    = rd_r.pending & ~(32'd1 << taken);
          out_nxt.signal_taken = taken;
        end
        default: begin
        end
      endcase
    end
    // report the entry after the operation; a freed or missing slot reads as zero
    if ((wr_en || set_used) && !clr_used) begin
      out_nxt.group_id_out    = entry_nxt.group_id;
      out_nxt.leader_id_out   = entry_nxt.leader_id;
      out_nxt.parent_id_out   = entry_nxt.parent_id;
      out_nxt.pgroup_id_out   = entry_nxt.pgroup_id;
      out_nxt.session_id_out  = entry_nxt.session_id;
      out_nxt.terminal_id_out = entry_nxt.terminal_id;
      out_nxt.exit_signal_out = entry_nxt.exit_sig;
      out_nxt.live_count_out  = entry_nxt.live_count;
    end
  end

  // control state and used bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (go && set_used) begin
        used_r[wr_addr] <= 1'b1;
      end
      if (go && clr_used) begin
        used_r[wr_addr] <= 1'b0;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= in_data;
      addr_r     <= SLOT_W'(in_data.slot);
      in_range_r <= (32'(in_data.slot) < 32'(MAX_SLOTS));
    end
    if (go) begin
      out_data_r <= out_nxt;
    end
  end

  // table memory: read on transfer in, write back in the modify step
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[SLOT_W'(in_data.slot)];
    end
    if (go && wr_en) begin
      mem[wr_addr] <= entry_nxt;
    end
  end

endmodule
